// ===== src/fdt_pkg.sv =====
// shared types, constants and helpers for the fixed directory table
`default_nettype none

package fdt_pkg;

    // default sizes of the table
    localparam int ENTRIES_DEF     = 16;
    localparam int NAME_BYTES_DEF  = 8;
    localparam int SECTOR_BITS_DEF = 10;

    // fixed widths of the channel fields
    localparam int ACTION_W        = 2;
    localparam int KEY_W           = 64;
    localparam int SECTOR_FIELD_W  = 10;
    localparam int STATUS_W        = 2;
    localparam int INDEX_FIELD_W   = 4;
    localparam int CFG_W           = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2
    } fdt_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_DUPLICATE = 2'd2,
        STS_FULL      = 2'd3
    } fdt_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fdt_state_t;

    // keep the low nbytes bytes, zero everything from the first zero byte on
    function automatic logic [KEY_W-1:0] normalize_name(input logic [KEY_W-1:0] key,
                                                         input int nbytes);
        logic [KEY_W-1:0] res;
        logic             stop;
        res  = '0;
        stop = 1'b0;
        for (int b = 0; b < KEY_W / 8; b++)
        begin
            if (b >= nbytes || key[8*b +: 8] == 8'h00)
                stop = 1'b1;
            if (!stop)
                res[8*b +: 8] = key[8*b +: 8];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/fdt_if.sv =====
// channel interfaces: request, response and configuration write
`default_nettype none

interface fdt_req_if;
    logic                            valid;
    logic                            ready;
    logic [fdt_pkg::ACTION_W-1:0]    action;
    logic [fdt_pkg::KEY_W-1:0]       name_key;
    logic [fdt_pkg::SECTOR_FIELD_W-1:0] new_sector;

    modport source (output valid, output action, output name_key, output new_sector,
                    input ready);
    modport sink   (input valid, input action, input name_key, input new_sector,
                    output ready);
endinterface

interface fdt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [fdt_pkg::STATUS_W-1:0]       status;
    logic [fdt_pkg::INDEX_FIELD_W-1:0]  entry_index;
    logic [fdt_pkg::SECTOR_FIELD_W-1:0] entry_sector;
    logic                               table_empty;

    modport source (output valid, output status, output entry_index,
                    output entry_sector, output table_empty, input ready);
    modport sink   (input valid, input status, input entry_index,
                    input entry_sector, input table_empty, output ready);
endinterface

interface fdt_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [fdt_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/fdt_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none

module fdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/fixed_directory_table_top.sv =====
// fixed directory table: linear scan over a name/sector ram with valid marks in flops
// a transaction reads one ram entry per active entry, min(entries_in_use, ENTRIES) in all,
// compares each with the key when its registered read data arrives, then ends in ST_FINISH,
// straight from accept if no entry is active; a new request is taken only in ST_IDLE.
// the next request is taken while a finished response still waits in the output register.
// reset clears the valid marks and sets entries_in_use to 16; the ram is not cleared.
`default_nettype none

module fixed_directory_table_top #(
    parameter int ENTRIES     = fdt_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES  = fdt_pkg::NAME_BYTES_DEF,
    parameter int SECTOR_BITS = fdt_pkg::SECTOR_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fdt_req_if.sink    req,
    fdt_rsp_if.source  rsp,
    fdt_cfg_if.sink    cfg
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int MEM_W  = NAME_W + SECTOR_BITS;

    fdt_pkg::fdt_state_t state_reg, state_next;

    logic [fdt_pkg::CFG_W-1:0]    cfg_reg, cfg_next;
    logic [ENTRIES-1:0]           valid_reg, valid_next;
    logic [CNT_W-1:0]             lim_reg, lim_next;
    logic [CNT_W-1:0]             rd_ptr_reg, rd_ptr_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic                         hit_reg, hit_next;
    logic                         free_reg, free_next;
    logic [CNT_W-1:0]             vcnt_reg, vcnt_next;
    logic                         out_valid_reg, out_valid_next;

    logic [fdt_pkg::ACTION_W-1:0] action_reg, action_next;
    logic [NAME_W-1:0]            key_reg, key_next;
    logic [SECTOR_BITS-1:0]       sector_reg, sector_next;
    logic [IDX_W-1:0]             cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]             hit_idx_reg, hit_idx_next;
    logic [SECTOR_BITS-1:0]       hit_sector_reg, hit_sector_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic [fdt_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [fdt_pkg::INDEX_FIELD_W-1:0]  out_index_reg, out_index_next;
    logic [fdt_pkg::SECTOR_FIELD_W-1:0] out_sector_reg, out_sector_next;
    logic                               out_empty_reg, out_empty_next;

    logic                   in_fire;
    logic                   finish_fire;
    logic [CNT_W-1:0]       lim_now;
    logic [31:0]            cfg_ext;
    logic [fdt_pkg::KEY_W-1:0] norm_key;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [MEM_W-1:0]       rd_data;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [MEM_W-1:0]       wr_data;
    logic [NAME_W-1:0]      rd_name;
    logic [SECTOR_BITS-1:0] rd_sector;
    logic                   entry_v;

    fdt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready   = (state_reg == fdt_pkg::ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign in_fire     = req.valid && req.ready;
    assign finish_fire = (state_reg == fdt_pkg::ST_FINISH) && (!out_valid_reg || rsp.ready);

    // active range saturates at the table size
    assign cfg_ext  = 32'(cfg_reg);
    assign lim_now  = (cfg_ext > 32'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cfg_ext);
    assign norm_key = fdt_pkg::normalize_name(req.name_key, NAME_BYTES);

    assign rd_name   = rd_data[MEM_W-1:SECTOR_BITS];
    assign rd_sector = rd_data[SECTOR_BITS-1:0];
    assign entry_v   = valid_reg[cmp_idx_reg];

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.entry_index  = out_index_reg;
    assign rsp.entry_sector = out_sector_reg;
    assign rsp.table_empty  = out_empty_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdt_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = (lim_now == '0) ? fdt_pkg::ST_FINISH : fdt_pkg::ST_SCAN;
            end
            fdt_pkg::ST_SCAN:
            begin
                // last compare happens in this cycle
                if (cmp_valid_reg && rd_ptr_reg == lim_reg)
                    state_next = fdt_pkg::ST_FINISH;
            end
            fdt_pkg::ST_FINISH:
            begin
                if (finish_fire)
                    state_next = fdt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cfg_next        = (cfg.valid && cfg.ready) ? cfg.data : cfg_reg;
        valid_next      = valid_reg;
        lim_next        = lim_reg;
        rd_ptr_next     = rd_ptr_reg;
        cmp_valid_next  = 1'b0;
        hit_next        = hit_reg;
        free_next       = free_reg;
        vcnt_next       = vcnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        action_next     = action_reg;
        key_next        = key_reg;
        sector_next     = sector_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_sector_next = hit_sector_reg;
        free_idx_next   = free_idx_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_sector_next = out_sector_reg;
        out_empty_next  = out_empty_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_ptr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = free_idx_reg;
        wr_data         = {key_reg, sector_reg};

        case (state_reg)
            fdt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    action_next = req.action;
                    key_next    = norm_key[NAME_W-1:0];
                    sector_next = SECTOR_BITS'(req.new_sector);
                    lim_next    = lim_now;
                    rd_ptr_next = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    vcnt_next   = '0;
                end
            end
            fdt_pkg::ST_SCAN:
            begin
                if (rd_ptr_reg != lim_reg)
                begin
                    rd_en          = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_ptr_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg)
                begin
                    if (entry_v)
                        vcnt_next = vcnt_reg + CNT_W'(1);
                    // first valid match wins
                    if (entry_v && rd_name == key_reg && !hit_reg)
                    begin
                        hit_next        = 1'b1;
                        hit_idx_next    = cmp_idx_reg;
                        hit_sector_next = rd_sector;
                    end
                    if (!entry_v && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
            end
            fdt_pkg::ST_FINISH:
            begin
                if (finish_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fdt_pkg::STS_OK;
                    out_index_next  = '0;
                    out_sector_next = '0;
                    out_empty_next  = (vcnt_reg == '0);
                    if (action_reg == fdt_pkg::ACT_ADD)
                    begin
                        if (hit_reg)
                        begin
                            out_status_next = fdt_pkg::STS_DUPLICATE;
                            out_index_next  = fdt_pkg::INDEX_FIELD_W'(hit_idx_reg);
                            out_sector_next = fdt_pkg::SECTOR_FIELD_W'(hit_sector_reg);
                        end
                        else if (free_reg)
                        begin
                            wr_en                    = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            out_index_next  = fdt_pkg::INDEX_FIELD_W'(free_idx_reg);
                            out_sector_next = fdt_pkg::SECTOR_FIELD_W'(sector_reg);
                            out_empty_next  = 1'b0;
                        end
                        else
                        begin
                            out_status_next = fdt_pkg::STS_FULL;
                        end
                    end
                    else if (hit_reg)
                    begin
                        out_index_next  = fdt_pkg::INDEX_FIELD_W'(hit_idx_reg);
                        out_sector_next = fdt_pkg::SECTOR_FIELD_W'(hit_sector_reg);
                        if (action_reg == fdt_pkg::ACT_REMOVE)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            out_empty_next          = (vcnt_reg == CNT_W'(1));
                        end
                    end
                    else
                    begin
                        out_status_next = fdt_pkg::STS_NOT_FOUND;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdt_pkg::ST_IDLE;
            cfg_reg       <= fdt_pkg::CFG_RESET;
            valid_reg     <= '0;
            lim_reg       <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            vcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            valid_reg     <= valid_next;
            lim_reg       <= lim_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            vcnt_reg      <= vcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        sector_reg     <= sector_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_sector_reg <= hit_sector_next;
        free_idx_reg   <= free_idx_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_sector_reg <= out_sector_next;
        out_empty_reg  <= out_empty_next;
    end

endmodule

`default_nettype wire
